/* rtl/core/pdhd_pkg.sv */
package pdhd_pkg;

    localparam int TIME_W      = 32;
    localparam int PAD_W       = 3;
    localparam int SAMPLE_W    = 12;
    localparam int WIN_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int THRESH_REGS = 6;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 16;

    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [PAD_W-1:0]    t_pad;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [WIN_W-1:0]    t_window;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESH0  = 3'd0,
        REG_THRESH1  = 3'd1,
        REG_THRESH2  = 3'd2,
        REG_THRESH3  = 3'd3,
        REG_THRESH4  = 3'd4,
        REG_THRESH5  = 3'd5,
        REG_DISABLED = 3'd6,
        REG_DEBOUNCE = 3'd7
    } t_cfg_idx;

    localparam t_sample THRESH_RESET [THRESH_REGS] = '{
        12'd450, 12'd500, 12'd800, 12'd600, 12'd1350, 12'd500
    };
    localparam t_pad    DISABLED_RESET = 3'd5;
    localparam t_window DEBOUNCE_RESET = 16'd80;

endpackage

/* rtl/core/pdhd_ram.sv */
module pdhd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read and write to one address in a cycle returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/piezo_pad_hit_detector_top.sv */
// scan results pass the evaluate stage and the output register; a full one can stall intake
// throughput: one pad request per cycle unless stalled; hit-time memory is read on accept
//   and written back in the evaluate stage, with a forwarding register covering the overlap
// reset: synchronous active-low; thresholds, disabled pad and debounce window return to
//   their defaults, every stored hit time reads as zero until first written
module piezo_pad_hit_detector_top #(
    parameter int PAD_COUNT = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // time_ms[31:0], pad_index[34:32], first_sample[46:35], confirm_sample[58:47], zeros
    input  logic [pdhd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // scan_end
    input  logic                             i_s_tlast,
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // hit_pad[2:0], hit_strength[14:3], zero
    output logic [pdhd_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // hit_found
    output logic                             o_m_tuser,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [pdhd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pdhd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    import pdhd_pkg::*;

    localparam int AW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    // configuration registers
    t_sample r_thresh [THRESH_REGS];
    t_pad    r_disabled;
    t_window r_debounce;

    // evaluate stage (item whose hit time is being read)
    logic    r_s1_valid;
    t_time   r_s1_time;
    t_pad    r_s1_pad;
    t_sample r_s1_first;
    t_sample r_s1_conf;
    logic    r_s1_last;

    // running winner of the current scan
    logic    r_best_found;
    t_pad    r_best_pad;
    t_sample r_best_strength;

    // per-pad written flags stand in for the all-zero reset of the hit-time store
    logic [PAD_COUNT-1:0] r_written;

    // last write-back, forwarded to the item that read the same entry alongside it
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_time         r_fwd_data;

    // output register
    logic    r_out_valid;
    logic    r_out_found;
    t_pad    r_out_pad;
    t_sample r_out_strength;

    // input fields
    t_time   in_time;
    t_pad    in_pad;
    t_sample in_first;
    t_sample in_conf;

    logic          advance;
    logic          s1_fire;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] s1_addr;
    t_time         ram_q;
    t_time         last_hit;
    t_time         since;
    t_sample       s1_thresh;
    logic          s1_eligible;
    logic          s1_qualifies;
    logic [SAMPLE_W:0] s1_sum;
    t_sample       s1_strength;
    logic          s1_beats;
    logic          fin_found;
    t_pad          fin_pad;
    t_sample       fin_strength;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign in_time  = i_s_tdata[TIME_W-1:0];
    assign in_pad   = i_s_tdata[TIME_W +: PAD_W];
    assign in_first = i_s_tdata[TIME_W+PAD_W +: SAMPLE_W];
    assign in_conf  = i_s_tdata[TIME_W+PAD_W+SAMPLE_W +: SAMPLE_W];

    // the pipe only halts when an end-of-scan result meets a full, unread output register
    assign advance    = !r_s1_valid || !r_s1_last || !r_out_valid || i_m_tready;
    assign o_s_tready = advance;
    assign s1_fire    = r_s1_valid && advance;

    assign rd_addr = AW'(in_pad);
    assign s1_addr = AW'(r_s1_pad);

    pdhd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (PAD_COUNT)
    ) u_hit_time_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_s1_time),
        .i_re    (advance),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // candidate evaluation
    always_comb begin
        s1_eligible = (32'(r_s1_pad) < PAD_COUNT) && (32'(r_s1_pad) < THRESH_REGS)
                      && (r_s1_pad != r_disabled);
        if (r_fwd_valid && (r_fwd_addr == s1_addr)) begin
            last_hit = r_fwd_data;
        end else if (s1_eligible && r_written[s1_addr]) begin
            last_hit = ram_q;
        end else begin
            last_hit = '0;
        end
        since     = r_s1_time - last_hit;
        s1_thresh = s1_eligible ? r_thresh[r_s1_pad] : '0;
        s1_qualifies = s1_eligible && (since >= TIME_W'(r_debounce))
                       && (r_s1_first >= s1_thresh) && (r_s1_conf >= s1_thresh);
        s1_sum      = {1'b0, r_s1_first} + {1'b0, r_s1_conf};
        s1_strength = s1_sum[SAMPLE_W:1];
        // strictly stronger only, so the earlier pad keeps a tie and zero never wins
        s1_beats    = s1_qualifies && (s1_strength > r_best_strength);

        if (s1_beats) begin
            fin_found    = 1'b1;
            fin_pad      = r_s1_pad;
            fin_strength = s1_strength;
        end else begin
            fin_found    = r_best_found;
            fin_pad      = r_best_pad;
            fin_strength = r_best_strength;
        end
    end

    // winner's hit time is stamped with the end-of-scan item's time
    assign wr_en   = s1_fire && r_s1_last && fin_found;
    assign wr_addr = AW'(fin_pad);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < THRESH_REGS; k++) begin
                r_thresh[k] <= THRESH_RESET[k];
            end
            r_disabled <= DISABLED_RESET;
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx)) inside
                REG_THRESH0, REG_THRESH1, REG_THRESH2,
                REG_THRESH3, REG_THRESH4, REG_THRESH5: begin
                    r_thresh[i_cfg_idx] <= i_cfg_wdata[SAMPLE_W-1:0];
                end
                REG_DISABLED: begin
                    r_disabled <= i_cfg_wdata[PAD_W-1:0];
                end
                REG_DEBOUNCE: begin
                    r_debounce <= i_cfg_wdata[WIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_best_found    <= 1'b0;
            r_best_pad      <= '0;
            r_best_strength <= '0;
            r_written       <= '0;
            r_fwd_valid     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (advance) begin
                r_s1_valid  <= i_s_tvalid;
                r_fwd_valid <= wr_en;
            end
            if (s1_fire) begin
                if (r_s1_last) begin
                    r_best_found    <= 1'b0;
                    r_best_pad      <= '0;
                    r_best_strength <= '0;
                end else if (s1_beats) begin
                    r_best_found    <= 1'b1;
                    r_best_pad      <= r_s1_pad;
                    r_best_strength <= s1_strength;
                end
            end
            if (wr_en) begin
                r_written[wr_addr] <= 1'b1;
            end
            if (s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_time  <= in_time;
            r_s1_pad   <= in_pad;
            r_s1_first <= in_first;
            r_s1_conf  <= in_conf;
            r_s1_last  <= i_s_tlast;
        end
        if (wr_en) begin
            r_fwd_addr <= wr_addr;
            r_fwd_data <= r_s1_time;
        end
        if (s1_fire && r_s1_last) begin
            r_out_found    <= fin_found;
            r_out_pad      <= fin_pad;
            r_out_strength <= fin_strength;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = M_TDATA_W'({r_out_strength, r_out_pad});

endmodule

/* test/piezo_pad_hit_detector_top_tb.sv */
`timescale 1ns / 1ps

module piezo_pad_hit_detector_top_tb;
    import pdhd_pkg::*;

    localparam int PADS       = 6;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int PHASE_REQS = 150;
    localparam int PHASES     = 8;
    localparam int SETTLE_CYC = 4;
    // far beyond the slowest legal run of about 1300 requests with gaps and stalls
    localparam longint TIMEOUT_NS = 400_000 * 12;

    // one scan report as it leaves the block
    typedef struct packed {
        logic    found;
        t_pad    pad;
        t_sample strength;
    } t_hit_report;

    // one line of the directed table: either a register write or a pad request
    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        t_window     wdata;
        t_time       at;
        t_pad        pad;
        t_sample     first;
        t_sample     confirm;
        bit          scan_end;
        bit          typed;
        t_hit_report want;
    } t_stim_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tlast   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // travels alongside each request so the checker knows whether a typed answer applies
    logic        row_typed  = 1'b0;
    t_hit_report row_expect = '0;

    // no sender gaps and no receiver stalls while set
    bit quiet = 1'b0;

    int fail_count    = 0;
    int req_count     = 0;
    int report_count  = 0;
    int sent_count    = 0;
    int setting_count = 0;

    // shadow copy of the block: registers, hit-time store and the running winner
    t_sample   pad_threshold [THRESH_REGS];
    t_pad      skip_pad;
    t_window   debounce_win;
    t_time     hit_time [PADS];
    logic      run_found;
    t_pad      run_pad;
    t_sample   run_strength;

    // scan reports still owed by the block, oldest first
    t_hit_report reports_due [$];

    piezo_pad_hit_detector_top #(
        .PAD_COUNT(PADS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------

    function automatic void clear_shadow();
        for (int k = 0; k < THRESH_REGS; k++) pad_threshold[k] = THRESH_RESET[k];
        for (int k = 0; k < PADS; k++) hit_time[k] = '0;
        skip_pad     = DISABLED_RESET;
        debounce_win = DEBOUNCE_RESET;
        run_found    = 1'b0;
        run_pad      = '0;
        run_strength = '0;
    endfunction

    // judge one pad request; a scan end closes the scan and yields its report
    function automatic bit score_pad_request(input t_time at, input t_pad pad,
                                             input t_sample first, input t_sample confirm,
                                             input bit scan_end, output t_hit_report rep);
        t_time                 since;
        logic [SAMPLE_W:0]     sum;
        rep = '0;
        if (pad < PADS && pad < THRESH_REGS && pad != skip_pad) begin
            since = at - hit_time[pad];
            // pad still inside its debounce window is not a candidate
            if (since >= t_time'(debounce_win)) begin
                if (first >= pad_threshold[pad] && confirm >= pad_threshold[pad]) begin
                    sum = {1'b0, first} + {1'b0, confirm};
                    // strictly stronger only: ties keep the earlier pad, zero never wins
                    if (sum[SAMPLE_W:1] > run_strength) begin
                        run_found    = 1'b1;
                        run_pad      = pad;
                        run_strength = sum[SAMPLE_W:1];
                    end
                end
            end
        end
        if (!scan_end) return 1'b0;
        // the hit time recorded is that of the closing request
        if (run_found) hit_time[run_pad] = at;
        rep.found    = run_found;
        rep.pad      = run_found ? run_pad : '0;
        rep.strength = run_found ? run_strength : '0;
        run_found    = 1'b0;
        run_pad      = '0;
        run_strength = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // monitor: inputs and outputs are all sampled on the same rising edge
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_hit_report rep;
        t_hit_report want;
        if (!i_rst_n) begin
            clear_shadow();
            reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_DISABLED: skip_pad     = i_cfg_wdata[PAD_W-1:0];
                    REG_DEBOUNCE: debounce_win = i_cfg_wdata[WIN_W-1:0];
                    default:      pad_threshold[i_cfg_idx] = i_cfg_wdata[SAMPLE_W-1:0];
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                req_count++;
                if (score_pad_request(i_s_tdata[31:0], i_s_tdata[34:32], i_s_tdata[46:35],
                                      i_s_tdata[58:47], i_s_tlast, rep)) begin
                    // a typed table answer stands in for the shadow model's one
                    reports_due.push_back(row_typed ? row_expect : rep);
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (reports_due.size() == 0) begin
                    $error("scan report with nothing pending: found %0d pad %0d strength %0d",
                           o_m_tuser, o_m_tdata[PAD_W-1:0], o_m_tdata[PAD_W+SAMPLE_W-1:PAD_W]);
                    fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    report_count++;
                    if (o_m_tuser !== want.found) begin
                        $error("hit_found: expected %0d, got %0d", want.found, o_m_tuser);
                        fail_count++;
                    end
                    if (o_m_tdata[PAD_W-1:0] !== want.pad) begin
                        $error("hit_pad: expected %0d, got %0d", want.pad,
                               o_m_tdata[PAD_W-1:0]);
                        fail_count++;
                    end
                    if (o_m_tdata[PAD_W+SAMPLE_W-1:PAD_W] !== want.strength) begin
                        $error("hit_strength: expected %0d, got %0d", want.strength,
                               o_m_tdata[PAD_W+SAMPLE_W-1:PAD_W]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver stalls at random about 21 percent of the time, never during the quiet phase
    always @(posedge i_clk) begin
        i_m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 21);
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // present one pad request, with random gaps ahead of it, and wait for the handshake
    task automatic send_item(input t_time at, input t_pad pad, input t_sample first,
                             input t_sample confirm, input bit scan_end,
                             input bit typed, input t_hit_report want);
        while (!quiet && $urandom_range(0, 99) < 21) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, confirm, first, pad, at};
        i_s_tlast  <= scan_end;
        row_typed  <= typed;
        row_expect <= want;
        do @(posedge i_clk); while (!o_s_tready);
        sent_count++;
    endtask

    // stop sending and let every owed report drain, plus the pipeline depth
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // one register write per cycle; the caller lowers the enable after a burst
    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic program_setting(input t_sample thr [THRESH_REGS], input t_pad dis,
                                   input t_window win);
        settle();
        for (int k = 0; k < THRESH_REGS; k++) begin
            set_reg(t_cfg_idx'(REG_THRESH0 + k), CFG_DATA_W'(thr[k]));
        end
        set_reg(REG_DISABLED, CFG_DATA_W'(dis));
        set_reg(REG_DEBOUNCE, win);
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    // samples cluster around the pad threshold so that hits and misses both occur
    function automatic t_sample pick_sample(input t_pad pad);
        int th;
        int v;
        th = (pad < THRESH_REGS) ? pad_threshold[pad] : $urandom_range(0, SAMPLE_MAX);
        case ($urandom_range(0, 4)) inside
            0:       v = $urandom_range(0, SAMPLE_MAX);
            1, 2:    v = th + $urandom_range(0, 60);
            3:       v = th - $urandom_range(1, 4);
            default: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        endcase
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return t_sample'(v);
    endfunction

    // mostly clean scans of every pad in order; the rest are short noisy runs with
    // out-of-range or repeated pads and a time that drifts inside the scan
    task automatic random_scan(input t_time at);
        bit   noisy;
        int   n;
        t_pad pad;
        t_time tm;
        noisy = ($urandom_range(0, 99) < 15);
        n     = noisy ? $urandom_range(1, 8) : PADS;
        for (int k = 0; k < n; k++) begin
            pad = noisy ? t_pad'($urandom_range(0, 7)) : t_pad'(k);
            tm  = (noisy && $urandom_range(0, 3) == 0) ? at + $urandom_range(0, 200) : at;
            send_item(tm, pad, pick_sample(pad), pick_sample(pad), k == n - 1, 1'b0, '0);
        end
    endtask

    function automatic t_stim_row req_row(input t_time at, input t_pad pad,
                                          input t_sample first, input t_sample confirm,
                                          input bit scan_end,
                                          input bit typed = 1'b0, input logic found = 1'b0,
                                          input t_pad hpad = '0, input t_sample str = '0);
        t_stim_row r;
        r         = '{idx: REG_THRESH0, default: '0};
        r.at      = at;
        r.pad     = pad;
        r.first   = first;
        r.confirm = confirm;
        r.scan_end = scan_end;
        r.typed   = typed;
        r.want    = '{found, hpad, str};
        return r;
    endfunction

    function automatic t_stim_row reg_row(input t_cfg_idx idx, input t_window val);
        t_stim_row r;
        r        = '{idx: REG_THRESH0, default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.wdata  = val;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        t_stim_row dir_rows [$];
        bit        prev_cfg;
        t_sample   thr [THRESH_REGS];
        t_pad      dis;
        t_window   win;
        t_time     scan_at;
        int        goal;

        // directed table, default registers: thresholds 450 500 800 600 1350 500,
        // pad 5 disabled, 80 ms debounce
        dir_rows = '{
            // early time: every pad still debounced against the zeroed hit times
            req_row(10, 0, 4095, 4095, 1, 1, 0, 0, 0),
            // full scan: exact threshold, one low sample, strongest pad, disabled pad
            req_row(100, 0, 450, 450, 0),
            req_row(100, 1, 499, 4095, 0),
            req_row(100, 2, 800, 801, 0),
            req_row(100, 3, 4095, 4095, 0),
            req_row(100, 4, 1350, 1349, 0),
            req_row(100, 5, 4095, 4095, 1, 1, 1, 3, 4095),
            // same pad 50 ms later is ignored
            req_row(150, 3, 4095, 4095, 1, 1, 0, 0, 0),
            // exactly one window later it counts again; pads 6 and 7 give nothing
            req_row(180, 3, 4095, 4094, 0),
            req_row(180, 6, 4095, 4095, 0),
            req_row(180, 7, 0, 0, 1, 1, 1, 3, 4094),
            // equal strength: earlier pad keeps the win
            req_row(300, 1, 1000, 1001, 0),
            req_row(300, 2, 1001, 1000, 1, 1, 1, 1, 1000),
            // zero threshold, yet a zero strength never wins
            reg_row(REG_THRESH0, 0),
            req_row(400, 0, 0, 1, 0),
            req_row(400, 1, 0, 0, 1, 1, 0, 0, 0),
            // hit time taken from the closing request, not the winning one
            req_row(500, 0, 10, 10, 0),
            req_row(600, 1, 0, 0, 1, 1, 1, 0, 10),
            req_row(650, 0, 100, 100, 1, 1, 0, 0, 0),
            // no pad disabled
            reg_row(REG_DISABLED, 7),
            req_row(1000, 5, 4095, 4095, 1, 1, 1, 5, 4095),
            // zero window, top of the time range and its wrap
            reg_row(REG_DEBOUNCE, 0),
            req_row(32'hFFFF_FFFF, 4, 1350, 1350, 1, 1, 1, 4, 1350),
            req_row(1, 4, 2000, 2001, 1, 1, 1, 4, 2000),
            // widest window: one ms short, then exactly on it
            reg_row(REG_DEBOUNCE, 16'hFFFF),
            req_row(32'h0000_FFFF, 4, 4095, 4095, 1, 1, 0, 0, 0),
            req_row(32'h0001_0000, 4, 4095, 4095, 1, 1, 1, 4, 4095)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_cfg = 1'b0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                // registers only change once the block has gone quiet
                if (!prev_cfg) settle();
                set_reg(dir_rows[k].idx, dir_rows[k].wdata);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) i_cfg_we <= 1'b0;
                send_item(dir_rows[k].at, dir_rows[k].pad, dir_rows[k].first,
                          dir_rows[k].confirm, dir_rows[k].scan_end,
                          dir_rows[k].typed, dir_rows[k].want);
                prev_cfg = 1'b0;
            end
        end

        // random phases, each under its own register setting
        scan_at = $urandom();
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    thr = THRESH_RESET;
                    dis = DISABLED_RESET;
                    win = DEBOUNCE_RESET;
                end
                1: begin
                    thr = '{default: '0};
                    dis = 3'd7;
                    win = '0;
                end
                2: begin
                    thr = '{default: SAMPLE_MAX};
                    dis = '0;
                    win = '1;
                end
                default: begin
                    foreach (thr[k]) thr[k] = t_sample'($urandom_range(0, SAMPLE_MAX));
                    dis = t_pad'($urandom_range(0, 7));
                    win = ($urandom_range(0, 3) == 0) ? t_window'($urandom())
                                                      : t_window'($urandom_range(1, 200));
                end
            endcase
            program_setting(thr, dis, win);
            // one phase runs flat out on both sides
            quiet = (ph == 4);
            goal  = sent_count + PHASE_REQS;
            while (sent_count < goal) begin
                // mostly steps around the window, now and then a jump that may wrap
                if ($urandom_range(0, 19) == 0) scan_at += $urandom();
                else scan_at += $urandom_range(0, 2 * debounce_win + 2);
                random_scan(scan_at);
            end
        end
        quiet = 1'b0;

        settle();
        $display("%0d pad requests sent, %0d scan reports checked", req_count, report_count);
        $display("%0d register settings, including all-zero and all-full thresholds",
                 setting_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/pdhd_pkg.sv
rtl/core/pdhd_ram.sv
rtl/core/piezo_pad_hit_detector_top.sv
test/piezo_pad_hit_detector_top_tb.sv
